// ===== sv/jsv_pkg.sv =====
// package: shared types, codes and helpers for the json syntax validator
package jsv_pkg;

  localparam int StackDepth = 64;
  localparam int CountWidth = 32;

  // parse states
  typedef enum logic [3:0] {
    PS_VALUE     = 4'd0,
    PS_ARR_START = 4'd1,
    PS_ARR_VALUE = 4'd2,
    PS_ARR_END   = 4'd3,
    PS_OBJ_START = 4'd4,
    PS_OBJ_KEY   = 4'd5,
    PS_OBJ_COLON = 4'd6,
    PS_OBJ_VALUE = 4'd7,
    PS_OBJ_END   = 4'd8,
    PS_END       = 4'd9
  } parse_state_t;

  // lexer substates
  typedef enum logic [4:0] {
    LX_IDLE     = 5'd0,
    LX_T_R      = 5'd1,
    LX_T_U      = 5'd2,
    LX_T_E      = 5'd3,
    LX_F_A      = 5'd4,
    LX_F_L      = 5'd5,
    LX_F_S      = 5'd6,
    LX_F_E      = 5'd7,
    LX_N_U      = 5'd8,
    LX_N_L1     = 5'd9,
    LX_N_L2     = 5'd10,
    LX_N_MINUS  = 5'd11,
    LX_N_ZERO   = 5'd12,
    LX_N_INT    = 5'd13,
    LX_N_DOT    = 5'd14,
    LX_N_FRAC   = 5'd15,
    LX_N_EXP    = 5'd16,
    LX_N_EXPSGN = 5'd17,
    LX_N_EXPDIG = 5'd18,
    LX_S_STR    = 5'd19,
    LX_S_ESC    = 5'd20,
    LX_S_HEX    = 5'd21,
    LX_S_SURBS  = 5'd22,
    LX_S_SURU   = 5'd23,
    LX_S_HEX2   = 5'd24
  } lex_state_t;

  // result codes
  localparam logic [4:0] ERR_NONE       = 5'd0;
  localparam logic [4:0] ERR_LITERAL    = 5'd1;
  localparam logic [4:0] ERR_MINUS      = 5'd2;
  localparam logic [4:0] ERR_DOT        = 5'd3;
  localparam logic [4:0] ERR_EXP        = 5'd4;
  localparam logic [4:0] ERR_VALUE      = 5'd5;
  localparam logic [4:0] ERR_ARR        = 5'd6;
  localparam logic [4:0] ERR_OBJ_START  = 5'd7;
  localparam logic [4:0] ERR_OBJ_KEY    = 5'd8;
  localparam logic [4:0] ERR_COLON      = 5'd9;
  localparam logic [4:0] ERR_OBJ_END    = 5'd10;
  localparam logic [4:0] ERR_TRAILING   = 5'd11;
  localparam logic [4:0] ERR_HEX        = 5'd12;
  localparam logic [4:0] ERR_SURROGATE  = 5'd13;
  localparam logic [4:0] ERR_ESCAPE     = 5'd14;
  localparam logic [4:0] ERR_CONTROL    = 5'd15;
  localparam logic [4:0] ERR_DEPTH      = 5'd16;

  localparam logic [15:0] SurLow  = 16'hD800;
  localparam logic [15:0] SurHigh = 16'hDBFF;
  localparam logic [7:0]  CtrlLimit = 8'h20;
  localparam logic [7:0]  Bom0 = 8'hEF;
  localparam logic [7:0]  Bom1 = 8'hBB;
  localparam logic [7:0]  Bom2 = 8'hBF;

  // stack access request from the parser to the stack memory
  typedef struct packed {
    logic push;
    logic kind;
  } stk_req_t;

  // expected byte for each literal substate
  function automatic logic [7:0] lit_char(input lex_state_t s);
    logic [7:0] r;
    r = 8'h00;
    unique case (s)
      LX_T_R:  r = "r";
      LX_T_U:  r = "u";
      LX_T_E:  r = "e";
      LX_F_A:  r = "a";
      LX_F_L:  r = "l";
      LX_F_S:  r = "s";
      LX_F_E:  r = "e";
      LX_N_U:  r = "u";
      LX_N_L1: r = "l";
      LX_N_L2: r = "l";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // substate after a matching literal byte
  function automatic lex_state_t lit_next(input lex_state_t s);
    lex_state_t r;
    r = LX_IDLE;
    unique case (s)
      LX_T_R:  r = LX_T_U;
      LX_T_U:  r = LX_T_E;
      LX_F_A:  r = LX_F_L;
      LX_F_L:  r = LX_F_S;
      LX_F_S:  r = LX_F_E;
      LX_N_U:  r = LX_N_L1;
      LX_N_L1: r = LX_N_L2;
      default: r = LX_IDLE;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h0;
    if (is_digit(c)) t = c - 8'h30;
    else if ((c >= "a") && (c <= "f")) t = c - 8'h57;
    else t = c - 8'h37;
    return t[3:0];
  endfunction

endpackage

// ===== sv/jsv_stack.sv =====
// nesting kind stack: one-bit memory with registered read of the top entry
module jsv_stack import jsv_pkg::*; #(
  parameter int STACK_DEPTH = StackDepth,
  parameter int LW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [LW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [LW-1:0] raddr,
  output logic          rdata
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic mem [STACK_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr[AW-1:0]] <= wdata;
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr[AW-1:0]];
  end
endmodule

// ===== sv/jsv_core.sv =====
// parser core: byte classification, lexer, parse state and position counters
module jsv_core import jsv_pkg::*; #(
  parameter int STACK_DEPTH = StackDepth,
  parameter int COUNT_WIDTH = CountWidth,
  parameter int LW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [6:0]    max_depth,
  input  logic          take,
  input  logic          start_req,
  input  logic [7:0]    byte_in,
  output logic          res_valid,
  output logic [4:0]    res_code,
  output logic [31:0]   res_line,
  output logic [31:0]   res_col,
  output logic          stk_we,
  output logic [LW-1:0] stk_waddr,
  output logic          stk_wdata,
  output logic          stk_re,
  output logic [LW-1:0] stk_raddr,
  input  logic          stk_rdata
);
  localparam logic [COUNT_WIDTH-1:0] CMax = '1;

  parse_state_t          ps, ps_next;
  lex_state_t            lx, lx_next;
  logic [2:0]            hcnt, hcnt_next;
  logic [15:0]           hval, hval_next;
  logic [LW-1:0]         level, level_next;
  logic [COUNT_WIDTH-1:0] line_cnt, line_cnt_next, col_cnt, col_cnt_next;
  logic [1:0]            bom, bom_next;
  logic                  done, done_next;
  // a pop leaves the new top kind pending in the stack read register
  logic                  pop_pend, pop_pend_next;
  logic                  emit;
  logic [4:0]            code;
  logic [COUNT_WIDTH-1:0] eline, ecol;
  stk_req_t              sreq;
  logic                  do_pop;

  // effective state with the pending pop resolved from the read data
  parse_state_t ps_cur;
  parse_state_t          b_ps;
  lex_state_t            b_lx;
  logic [2:0]            b_hcnt;
  logic [15:0]           b_hval;
  logic [LW-1:0]         b_level;
  logic [COUNT_WIDTH-1:0] b_line, b_col;
  logic [1:0]            b_bom;
  logic                  b_done;
  logic [LW-1:0]         lim;
  logic [2:0]            hinc;
  logic [15:0]           hnew;
  logic                  structural;

  always_comb begin
    ps_cur = ps;
    if (pop_pend) ps_cur = stk_rdata ? PS_OBJ_END : PS_ARR_END;
  end

  always_comb begin
    if (int'(max_depth) > STACK_DEPTH) lim = LW'(STACK_DEPTH);
    else lim = LW'(max_depth);
  end

  // next state of one byte
  always_comb begin
    b_ps = ps_cur; b_lx = lx; b_hcnt = hcnt; b_hval = hval; b_level = level;
    b_line = line_cnt; b_col = col_cnt; b_bom = bom; b_done = done;
    if (start_req) begin
      b_ps = PS_VALUE; b_lx = LX_IDLE; b_hcnt = '0; b_hval = '0; b_level = '0;
      b_line = COUNT_WIDTH'(1); b_col = '0; b_bom = '0; b_done = 1'b0;
    end
    ps_next = b_ps; lx_next = b_lx; hcnt_next = b_hcnt; hval_next = b_hval;
    level_next = b_level; line_cnt_next = b_line; col_cnt_next = b_col;
    bom_next = b_bom; done_next = b_done; pop_pend_next = 1'b0;
    emit = 1'b0; code = ERR_NONE; eline = b_line; ecol = b_col;
    sreq = '0; do_pop = 1'b0; structural = 1'b0;
    hinc = b_hcnt + 3'd1;
    hnew = {b_hval[11:0], hex_of(byte_in)};
    if (take && !(b_done && !start_req)) begin
      if (b_bom == 2'd0 && byte_in == Bom0) begin
        bom_next = 2'd1;
      end else if (b_bom == 2'd1 || b_bom == 2'd2) begin
        if ((b_bom == 2'd1 && byte_in == Bom1) || (b_bom == 2'd2 && byte_in == Bom2)) begin
          bom_next = b_bom + 2'd1;
        end else begin
          emit = 1'b1; code = ERR_VALUE;
          eline = COUNT_WIDTH'(1); ecol = COUNT_WIDTH'(1);
        end
      end else begin
        bom_next = 2'd3;
        if (b_col != CMax) col_cnt_next = b_col + 1'b1;
        ecol = col_cnt_next;
        // lexer
        if (b_lx >= LX_S_STR) begin
          priority case (b_lx)
            LX_S_STR: begin
              if (byte_in == "\"") lx_next = LX_IDLE;
              else if (byte_in == "\\") lx_next = LX_S_ESC;
              else if (byte_in < CtrlLimit) begin emit = 1'b1; code = ERR_CONTROL; end
            end
            LX_S_ESC: begin
              if (byte_in == "u") begin
                lx_next = LX_S_HEX; hcnt_next = '0; hval_next = '0;
              end else if (byte_in == "\\" || byte_in == "/" || byte_in == "\"" ||
                           byte_in == "b" || byte_in == "f" || byte_in == "n" ||
                           byte_in == "r" || byte_in == "t") begin
                lx_next = LX_S_STR;
              end else begin emit = 1'b1; code = ERR_ESCAPE; end
            end
            LX_S_HEX, LX_S_HEX2: begin
              if (!is_hex(byte_in)) begin emit = 1'b1; code = ERR_HEX; end
              else begin
                if (b_lx == LX_S_HEX) hval_next = hnew;
                hcnt_next = hinc;
                if (hinc >= 3'd4) begin
                  hcnt_next = '0;
                  if (b_lx == LX_S_HEX && hnew >= SurLow && hnew <= SurHigh)
                    lx_next = LX_S_SURBS;
                  else lx_next = LX_S_STR;
                end
              end
            end
            LX_S_SURBS: begin
              if (byte_in != "\\") begin emit = 1'b1; code = ERR_SURROGATE; end
              else lx_next = LX_S_SURU;
            end
            default: begin
              if (byte_in != "u") begin emit = 1'b1; code = ERR_SURROGATE; end
              else begin lx_next = LX_S_HEX2; hcnt_next = '0; end
            end
          endcase
        end else if (b_lx >= LX_T_R && b_lx <= LX_N_L2) begin
          if (byte_in != lit_char(b_lx)) begin emit = 1'b1; code = ERR_LITERAL; end
          else lx_next = lit_next(b_lx);
        end else if (b_lx >= LX_N_MINUS) begin
          priority if (b_lx == LX_N_MINUS) begin
            if (byte_in == "0") lx_next = LX_N_ZERO;
            else if (is_digit(byte_in)) lx_next = LX_N_INT;
            else begin emit = 1'b1; code = ERR_MINUS; end
          end else if (b_lx == LX_N_DOT) begin
            if (is_digit(byte_in)) lx_next = LX_N_FRAC;
            else begin emit = 1'b1; code = ERR_DOT; end
          end else if (b_lx == LX_N_EXP || b_lx == LX_N_EXPSGN) begin
            if (is_digit(byte_in)) lx_next = LX_N_EXPDIG;
            else if (b_lx == LX_N_EXP && (byte_in == "+" || byte_in == "-"))
              lx_next = LX_N_EXPSGN;
            else begin emit = 1'b1; code = ERR_EXP; end
          end else if ((b_lx == LX_N_INT || b_lx == LX_N_FRAC || b_lx == LX_N_EXPDIG) &&
                       is_digit(byte_in)) begin
            lx_next = b_lx;
          end else if ((b_lx == LX_N_ZERO || b_lx == LX_N_INT) && byte_in == ".") begin
            lx_next = LX_N_DOT;
          end else if (b_lx != LX_N_EXPDIG && (byte_in == "e" || byte_in == "E")) begin
            lx_next = LX_N_EXP;
          end else begin
            structural = 1'b1;
          end
        end else begin
          structural = 1'b1;
        end
        // structure
        if (structural) begin
          lx_next = LX_IDLE;
          if (!(byte_in == " " || byte_in == 8'h0A || byte_in == 8'h0D || byte_in == 8'h09)) begin
            // closers and separators
            priority if ((b_ps == PS_ARR_START || b_ps == PS_ARR_END) && byte_in == "]") begin
              do_pop = 1'b1;
            end else if ((b_ps == PS_OBJ_START || b_ps == PS_OBJ_END) && byte_in == "}") begin
              do_pop = 1'b1;
            end else if (b_ps == PS_ARR_END) begin
              if (byte_in == ",") ps_next = PS_ARR_VALUE;
              else begin emit = 1'b1; code = ERR_ARR; end
            end else if (b_ps == PS_OBJ_START || b_ps == PS_OBJ_KEY) begin
              if (byte_in == "\"") begin lx_next = LX_S_STR; ps_next = PS_OBJ_COLON; end
              else begin
                emit = 1'b1; code = (b_ps == PS_OBJ_START) ? ERR_OBJ_START : ERR_OBJ_KEY;
              end
            end else if (b_ps == PS_OBJ_COLON) begin
              if (byte_in == ":") ps_next = PS_OBJ_VALUE;
              else begin emit = 1'b1; code = ERR_COLON; end
            end else if (b_ps == PS_OBJ_END) begin
              if (byte_in == ",") ps_next = PS_OBJ_KEY;
              else begin emit = 1'b1; code = ERR_OBJ_END; end
            end else if (b_ps == PS_END) begin
              emit = 1'b1; code = (byte_in == 8'h00) ? ERR_NONE : ERR_TRAILING;
            end else begin
              // begin a value
              if (byte_in == "[" || byte_in == "{") begin
                if (b_level >= lim) begin emit = 1'b1; code = ERR_DEPTH; end
                else begin
                  sreq.push = 1'b1; sreq.kind = (byte_in == "{");
                  level_next = b_level + 1'b1;
                  ps_next = (byte_in == "{") ? PS_OBJ_START : PS_ARR_START;
                end
              end else begin
                priority if (byte_in == "t") lx_next = LX_T_R;
                else if (byte_in == "f") lx_next = LX_F_A;
                else if (byte_in == "n") lx_next = LX_N_U;
                else if (byte_in == "\"") lx_next = LX_S_STR;
                else if (byte_in == "-") lx_next = LX_N_MINUS;
                else if (byte_in == "0") lx_next = LX_N_ZERO;
                else if (is_digit(byte_in)) lx_next = LX_N_INT;
                else begin emit = 1'b1; code = ERR_VALUE; end
                if (!emit) begin
                  if (b_ps == PS_VALUE) ps_next = PS_END;
                  else if (b_ps == PS_OBJ_VALUE) ps_next = PS_OBJ_END;
                  else ps_next = PS_ARR_END;
                end
              end
            end
            if (do_pop) begin
              if (b_level != '0) level_next = b_level - 1'b1;
              if (level_next == '0) ps_next = PS_END;
              else pop_pend_next = 1'b1;
            end
          end
        end
        if (!emit && byte_in == 8'h0A) begin
          if (b_line != CMax) line_cnt_next = b_line + 1'b1;
          col_cnt_next = '0;
        end
      end
      if (emit) done_next = 1'b1;
    end else if (take) begin
      ps_next = b_ps;
    end
  end

  // stack access: push writes the new top, pop reads the kind below
  assign stk_we    = sreq.push;
  assign stk_waddr = b_level;
  assign stk_wdata = sreq.kind;
  assign stk_re    = pop_pend_next;
  assign stk_raddr = level_next - 1'b1;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= PS_VALUE; lx <= LX_IDLE; hcnt <= '0; hval <= '0; level <= '0;
      line_cnt <= COUNT_WIDTH'(1); col_cnt <= '0; bom <= '0; done <= 1'b0;
      pop_pend <= 1'b0;
    end else if (take) begin
      ps <= ps_next; lx <= lx_next; hcnt <= hcnt_next; hval <= hval_next;
      level <= level_next; line_cnt <= line_cnt_next; col_cnt <= col_cnt_next;
      bom <= bom_next; done <= done_next; pop_pend <= pop_pend_next;
    end
  end

  // result, saturated to 32 bits
  assign res_valid = take && emit;
  assign res_code  = code;
  always_comb begin
    if (COUNT_WIDTH > 32 && eline > COUNT_WIDTH'(32'hFFFFFFFF)) res_line = '1;
    else res_line = 32'(eline);
    if (COUNT_WIDTH > 32 && ecol > COUNT_WIDTH'(32'hFFFFFFFF)) res_col = '1;
    else res_col = 32'(ecol);
  end
endmodule

// ===== sv/json_syntax_validator_top.sv =====
// top level: json syntax validator with config register and output register
// Checks a JSON document one byte per cycle, a new byte accepted every cycle while the
// result register is free or being taken. The nesting stack sits in a one-bit memory with
// a registered read; a closing bracket starts the read of the enclosing kind, which is ready
// for the next byte. One request with error_code, line_number and column_number comes out
// per document, in the cycle after its deciding byte is taken. start_req restarts a document;
// max_depth may only be written while the block is idle.
module json_syntax_validator_top import jsv_pkg::*; #(
  parameter int STACK_DEPTH = StackDepth,
  parameter int COUNT_WIDTH = CountWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  max_depth,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  error_code,
  output logic [31:0] line_number,
  output logic [31:0] column_number
);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  logic [6:0]    depth_reg;
  logic          take;
  logic          res_valid;
  logic [4:0]    res_code;
  logic [31:0]   res_line, res_col;
  logic          stk_we, stk_re, stk_wdata, stk_rdata;
  logic [LW-1:0] stk_waddr, stk_raddr;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) depth_reg <= 7'd64;
    else if (cfg_valid) depth_reg <= max_depth;
  end

  // stall only while a result waits and is held
  assign in_stall = out_valid && out_stall;
  assign take = in_valid && !in_stall;

  jsv_core #(.STACK_DEPTH(STACK_DEPTH), .COUNT_WIDTH(COUNT_WIDTH), .LW(LW)) u_core (
    .clk, .rst, .max_depth(depth_reg), .take, .start_req, .byte_in,
    .res_valid, .res_code, .res_line, .res_col,
    .stk_we, .stk_waddr, .stk_wdata, .stk_re, .stk_raddr, .stk_rdata
  );

  jsv_stack #(.STACK_DEPTH(STACK_DEPTH), .LW(LW)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!in_stall) out_valid <= res_valid;
  end
  always_ff @(posedge clk) begin
    if (!in_stall && res_valid) begin
      error_code    <= res_code;
      line_number   <= res_line;
      column_number <= res_col;
    end
  end
endmodule

// ===== sv/jsv_checker.sv =====
// port checker for the json syntax validator, bound to the top level
module jsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  error_code,
  input logic [31:0] line_number
);
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code <= 5'd16) else $error("code out of range");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != 32'd0) else $error("line zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(error_code)) else $error("result dropped");
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("stall without result");
endmodule

bind json_syntax_validator_top jsv_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .error_code, .line_number
);

// ===== bench/tb_json_syntax_validator_top.sv =====
// testbench: json syntax validator checked against its own byte-level predictor
module tb_json_syntax_validator_top;
  import jsv_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  max_depth;
  logic        in_valid;
  logic        in_stall;
  logic        start_req;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  error_code;
  logic [31:0] line_number;
  logic [31:0] column_number;

  typedef struct packed {
    logic       first;
    logic [7:0] ch;
  } doc_byte_t;

  typedef struct packed {
    logic [4:0]  code;
    logic [31:0] line;
    logic [31:0] col;
  } verdict_t;

  doc_byte_t pending_bytes[$];
  verdict_t  expected_verdicts[$];
  int        fail_count;
  int        bytes_sent;
  int        verdicts_seen;
  int        hold_gap;
  int        stall_gap;
  bit        driver_paused;

  // predictor state
  logic [6:0]   p_max_depth;
  parse_state_t p_ps;
  lex_state_t   p_lx;
  logic [2:0]   p_hex_cnt;
  logic [15:0]  p_hex_val;
  logic         p_kinds[StackDepth];
  int           p_level;
  logic [31:0]  p_line;
  logic [31:0]  p_col;
  int           p_bom;
  logic         p_done;

  json_syntax_validator_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_depth(max_depth),
    .in_valid(in_valid), .in_stall(in_stall), .start_req(start_req), .byte_in(byte_in),
    .out_valid(out_valid), .out_stall(out_stall), .error_code(error_code),
    .line_number(line_number), .column_number(column_number)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --- predictor ---
  function automatic void clear_doc();
    p_ps = PS_VALUE;
    p_lx = LX_IDLE;
    p_hex_cnt = 3'd0;
    p_hex_val = 16'd0;
    p_level = 0;
    p_line = 32'd1;
    p_col = 32'd0;
    p_bom = 0;
    p_done = 1'b0;
  endfunction

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hexval(logic [7:0] c);
    if (dig(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void mark_value_done();
    if (p_ps == PS_VALUE) p_ps = PS_END;
    else if (p_ps == PS_OBJ_VALUE) p_ps = PS_OBJ_END;
    else p_ps = PS_ARR_END;
  endfunction

  function automatic void close_level();
    if (p_level > 0) p_level--;
    if (p_level == 0) p_ps = PS_END;
    else p_ps = p_kinds[p_level - 1] ? PS_OBJ_END : PS_ARR_END;
  endfunction

  function automatic int open_level(logic kind);
    int lim;
    lim = (p_max_depth > StackDepth) ? StackDepth : p_max_depth;
    if (p_level >= lim) return ERR_DEPTH;
    p_kinds[p_level] = kind;
    p_level++;
    p_ps = kind ? PS_OBJ_START : PS_ARR_START;
    return -1;
  endfunction

  function automatic int start_value(logic [7:0] c);
    case (c)
      "[": return open_level(1'b0);
      "{": return open_level(1'b1);
      "t": p_lx = LX_T_R;
      "f": p_lx = LX_F_A;
      "n": p_lx = LX_N_U;
      "\"": p_lx = LX_S_STR;
      "-": p_lx = LX_N_MINUS;
      "0": p_lx = LX_N_ZERO;
      default: begin
        if (c >= "1" && c <= "9") p_lx = LX_N_INT;
        else return ERR_VALUE;
      end
    endcase
    mark_value_done();
    return -1;
  endfunction

  function automatic int string_char(logic [7:0] c);
    int d;
    case (p_lx)
      LX_S_STR: begin
        if (c == "\"") p_lx = LX_IDLE;
        else if (c == "\\") p_lx = LX_S_ESC;
        else if (c < CtrlLimit) return ERR_CONTROL;
        return -1;
      end
      LX_S_ESC: begin
        if (c == "u") begin
          p_lx = LX_S_HEX;
          p_hex_cnt = 3'd0;
          p_hex_val = 16'd0;
        end else if (c == "\\" || c == "/" || c == "\"" || c == "b" || c == "f" ||
                     c == "n" || c == "r" || c == "t") begin
          p_lx = LX_S_STR;
        end else begin
          return ERR_ESCAPE;
        end
        return -1;
      end
      LX_S_HEX, LX_S_HEX2: begin
        d = hexval(c);
        if (d < 0) return ERR_HEX;
        if (p_lx == LX_S_HEX) p_hex_val = {p_hex_val[11:0], 4'(d)};
        p_hex_cnt = p_hex_cnt + 3'd1;
        if (p_hex_cnt >= 3'd4) begin
          p_hex_cnt = 3'd0;
          if (p_lx == LX_S_HEX && p_hex_val >= SurLow && p_hex_val <= SurHigh)
            p_lx = LX_S_SURBS;
          else
            p_lx = LX_S_STR;
        end
        return -1;
      end
      LX_S_SURBS: begin
        if (c != "\\") return ERR_SURROGATE;
        p_lx = LX_S_SURU;
        return -1;
      end
      default: begin
        if (c != "u") return ERR_SURROGATE;
        p_lx = LX_S_HEX2;
        p_hex_cnt = 3'd0;
        return -1;
      end
    endcase
  endfunction

  // 1 continued, 0 ended, otherwise an error code plus 100
  function automatic int number_char(logic [7:0] c);
    lex_state_t s;
    s = p_lx;
    if (s == LX_N_MINUS) begin
      if (c == "0") begin p_lx = LX_N_ZERO; return 1; end
      if (c >= "1" && c <= "9") begin p_lx = LX_N_INT; return 1; end
      return 100 + ERR_MINUS;
    end
    if (s == LX_N_DOT) begin
      if (dig(c)) begin p_lx = LX_N_FRAC; return 1; end
      return 100 + ERR_DOT;
    end
    if (s == LX_N_EXP || s == LX_N_EXPSGN) begin
      if (dig(c)) begin p_lx = LX_N_EXPDIG; return 1; end
      if (s == LX_N_EXP && (c == "+" || c == "-")) begin p_lx = LX_N_EXPSGN; return 1; end
      return 100 + ERR_EXP;
    end
    if ((s == LX_N_INT || s == LX_N_FRAC || s == LX_N_EXPDIG) && dig(c)) return 1;
    if ((s == LX_N_ZERO || s == LX_N_INT) && c == ".") begin p_lx = LX_N_DOT; return 1; end
    if (s != LX_N_EXPDIG && (c == "e" || c == "E")) begin p_lx = LX_N_EXP; return 1; end
    p_lx = LX_IDLE;
    return 0;
  endfunction

  function automatic int consume_char(logic [7:0] c);
    int r;
    if (p_lx >= LX_S_STR) return string_char(c);
    if (p_lx >= LX_T_R && p_lx <= LX_N_L2) begin
      if (c != lit_char(p_lx)) return ERR_LITERAL;
      p_lx = lit_next(p_lx);
      return -1;
    end
    if (p_lx >= LX_N_MINUS) begin
      r = number_char(c);
      if (r == 1) return -1;
      if (r >= 100) return r - 100;
    end
    p_lx = LX_IDLE;
    if (c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09) return -1;
    case (p_ps)
      PS_ARR_START: begin
        if (c == "]") begin close_level(); return -1; end
        return start_value(c);
      end
      PS_VALUE, PS_ARR_VALUE, PS_OBJ_VALUE: return start_value(c);
      PS_ARR_END: begin
        if (c == "]") begin close_level(); return -1; end
        if (c == ",") begin p_ps = PS_ARR_VALUE; return -1; end
        return ERR_ARR;
      end
      PS_OBJ_START, PS_OBJ_KEY: begin
        if (c == "}" && p_ps == PS_OBJ_START) begin close_level(); return -1; end
        if (c == "\"") begin p_lx = LX_S_STR; p_ps = PS_OBJ_COLON; return -1; end
        return (p_ps == PS_OBJ_START) ? ERR_OBJ_START : ERR_OBJ_KEY;
      end
      PS_OBJ_COLON: begin
        if (c == ":") begin p_ps = PS_OBJ_VALUE; return -1; end
        return ERR_COLON;
      end
      PS_OBJ_END: begin
        if (c == "}") begin close_level(); return -1; end
        if (c == ",") begin p_ps = PS_OBJ_KEY; return -1; end
        return ERR_OBJ_END;
      end
      default: return (c == 8'h00) ? ERR_NONE : ERR_TRAILING;
    endcase
  endfunction

  function automatic void predict_byte(doc_byte_t b);
    int code;
    verdict_t v;
    if (b.first) clear_doc();
    else if (p_done) return;
    // byte order mark prefix
    if (p_bom == 0) begin
      if (b.ch == Bom0) begin p_bom = 1; return; end
      p_bom = 3;
    end else if (p_bom == 1 || p_bom == 2) begin
      if ((p_bom == 1 && b.ch == Bom1) || (p_bom == 2 && b.ch == Bom2)) begin
        p_bom++;
        return;
      end
      v = '{ERR_VALUE, 32'd1, 32'd1};
      expected_verdicts.push_back(v);
      p_done = 1'b1;
      return;
    end
    if (p_col != 32'hFFFF_FFFF) p_col++;
    code = consume_char(b.ch);
    if (code >= 0) begin
      v = '{5'(code), p_line, p_col};
      expected_verdicts.push_back(v);
      p_done = 1'b1;
      return;
    end
    if (b.ch == 8'h0a) begin
      if (p_line != 32'hFFFF_FFFF) p_line++;
      p_col = 32'd0;
    end
  endfunction

  // --- stimulus builders ---
  // single raw byte, the only way a zero byte reaches the queue
  function automatic void add_byte(logic [7:0] ch, bit first_flag);
    doc_byte_t b;
    b.first = first_flag;
    b.ch = ch;
    pending_bytes.push_back(b);
  endfunction

  function automatic void add_text(string s, bit first_flag);
    doc_byte_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.first = first_flag && (i == 0);
      b.ch = s[i];
      pending_bytes.push_back(b);
    end
  endfunction

  function automatic void add_doc(string s);
    add_text(s, 1'b1);
    add_byte(8'h00, 1'b0);
  endfunction

  function automatic string rand_ws();
    case ($urandom_range(0, 7))
      0: return " ";
      1: return "\n";
      2: return "\t";
      3: return "\r\n ";
      default: return "";
    endcase
  endfunction

  function automatic string rand_number();
    string s;
    s = ($urandom_range(0, 2) == 0) ? "-" : "";
    if ($urandom_range(0, 3) == 0) s = {s, "0"};
    else begin
      s = {s, string'(8'("1" + $urandom_range(0, 8)))};
      repeat ($urandom_range(0, 3)) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    end
    if ($urandom_range(0, 2) == 0) s = {s, ".", string'(8'("0" + $urandom_range(0, 9)))};
    if ($urandom_range(0, 3) == 0) begin
      s = {s, ($urandom_range(0, 1) ? "e" : "E")};
      case ($urandom_range(0, 2))
        0: s = {s, "+"};
        1: s = {s, "-"};
        default: ;
      endcase
      s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    end
    return s;
  endfunction

  function automatic string rand_hex4(bit lead_sur);
    string hx, s;
    hx = "0123456789abcdefABCDEF";
    s = lead_sur ? {"d", string'(hx[$urandom_range(8, 11)])} : "";
    while (s.len() < 4) s = {s, string'(hx[$urandom_range(0, 21)])};
    return s;
  endfunction

  function automatic string rand_string();
    string s;
    string esc;
    esc = "\\/\"bfnrt";
    s = "\"";
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0: s = {s, "\\", string'(esc[$urandom_range(0, 7)])};
        1: s = {s, "\\u", rand_hex4(1'b0)};
        2: s = {s, "\\u", rand_hex4(1'b1), "\\u", rand_hex4(1'b0)};
        3: s = {s, string'(8'($urandom_range(8'h80, 8'hff)))};
        default: s = {s, string'(8'($urandom_range(8'h20, 8'h7e) == 8'h22 ? "a" :
                                  $urandom_range(8'h23, 8'h5b)))};
      endcase
    end
    return {s, "\""};
  endfunction

  function automatic string rand_value(int lvl);
    string s;
    int n;
    case ((lvl > 5) ? $urandom_range(0, 3) : $urandom_range(0, 6))
      0: s = rand_number();
      1: s = rand_string();
      2: s = ($urandom_range(0, 2) == 0) ? "true" : ($urandom_range(0, 1) ? "false" : "null");
      3: s = rand_number();
      4, 5: begin
        n = $urandom_range(0, 3);
        s = "[";
        for (int i = 0; i < n; i++)
          s = {s, (i > 0) ? "," : "", rand_ws(), rand_value(lvl + 1), rand_ws()};
        s = {s, "]"};
      end
      default: begin
        n = $urandom_range(0, 3);
        s = "{";
        for (int i = 0; i < n; i++)
          s = {s, (i > 0) ? "," : "", rand_ws(), rand_string(), rand_ws(), ":", rand_ws(),
               rand_value(lvl + 1), rand_ws()};
        s = {s, "}"};
      end
    endcase
    return s;
  endfunction

  // break a good document: flip, drop or insert one byte
  function automatic string corrupt(string s);
    int k;
    string t;
    if (s.len() == 0) return s;
    k = $urandom_range(0, s.len() - 1);
    case ($urandom_range(0, 2))
      0: s[k] = 8'($urandom_range(1, 255));
      1: begin
        t = s.substr(0, k - 1);
        s = {t, s.substr(k + 1, s.len() - 1)};
      end
      default: begin
        t = s.substr(0, k - 1);
        s = {t, string'(8'($urandom_range(1, 255))), s.substr(k, s.len() - 1)};
      end
    endcase
    return s;
  endfunction

  function automatic string nest(int d);
    string s;
    s = "";
    for (int i = 0; i < d; i++) s = {s, (i % 2) ? "{\"k\":" : "["};
    s = {s, "1"};
    for (int i = d - 1; i >= 0; i--) s = {s, (i % 2) ? "}" : "]"};
    return s;
  endfunction

  // --- driver ---
  always @(posedge clk) begin
    doc_byte_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte({start_req, byte_in});
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (hold_gap > 0) begin
          hold_gap--;
          in_valid <= 1'b0;
        end else if (!driver_paused && pending_bytes.size() > 0) begin
          b = pending_bytes.pop_front();
          in_valid <= 1'b1;
          start_req <= b.first;
          byte_in <= b.ch;
          case ($urandom_range(0, 19))
            0, 1, 2: hold_gap = $urandom_range(1, 3);
            3: hold_gap = $urandom_range(10, 40);
            default: hold_gap = 0;
          endcase
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --- monitor ---
  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("unexpected request: code %0d", error_code);
          fail_count++;
        end else begin
          e = expected_verdicts.pop_front();
          if (error_code !== e.code) begin
            $error("error_code: expected %0d, actual %0d", e.code, error_code);
            fail_count++;
          end
          if (line_number !== e.line) begin
            $error("line_number: expected %0d, actual %0d", e.line, line_number);
            fail_count++;
          end
          if (column_number !== e.col) begin
            $error("column_number: expected %0d, actual %0d", e.col, column_number);
            fail_count++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: stall_gap = $urandom_range(0, 2);
          3: stall_gap = $urandom_range(10, 40);
          default: stall_gap = 0;
        endcase
        out_stall <= (stall_gap > 0);
      end
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_depth(logic [6:0] d);
    cfg_valid <= 1'b1;
    max_depth <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    p_max_depth = d;
    @(posedge clk);
  endtask

  task automatic run_random(int n_bytes);
    string s;
    int target;
    target = bytes_sent + pending_bytes.size() + n_bytes;
    while (bytes_sent + pending_bytes.size() < target) begin
      if (pending_bytes.size() > 40) begin
        @(posedge clk);
        continue;
      end
      s = {rand_ws(), rand_value(0), rand_ws()};
      case ($urandom_range(0, 9))
        0, 1: s = corrupt(s);
        2: s = {string'(8'hef), string'(8'hbb), string'(8'hbf), s};
        3: s = {string'(8'hef), string'(8'($urandom_range(1, 255))), s};
        4: s = {s, string'(8'($urandom_range(1, 255)))};
        default: ;
      endcase
      if ($urandom_range(0, 15) == 0) begin
        add_text(s, 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        add_doc(s);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    max_depth = 7'd64;
    in_valid = 1'b0;
    start_req = 1'b0;
    byte_in = 8'h00;
    out_stall = 1'b0;
    fail_count = 0;
    bytes_sent = 0;
    verdicts_seen = 0;
    hold_gap = 0;
    stall_gap = 0;
    driver_paused = 1'b0;
    p_max_depth = 7'd64;
    clear_doc();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset depth, bytes without a start flag, every error kind
    add_text("[1]", 1'b0);
    add_byte(8'h00, 1'b0);
    add_doc("tru");
    add_doc("-x");
    add_doc("1.e");
    add_doc("1e+");
    add_doc("]");
    add_doc("[1 2]");
    add_doc("{1}");
    add_doc("{\"a\":1,2}");
    add_doc("{\"a\" 1}");
    add_doc("{\"a\":1 2}");
    add_doc("01");
    add_doc("\"\\u12g4\"");
    add_doc("\"\\ud800x\"");
    add_doc("\"\\udbff\\x\"");
    add_doc("\"\\q\"");
    add_doc({"\"", string'(8'h01), "\""});
    add_doc({string'(8'hef), string'(8'hbb), string'(8'hbf),
             "{\"k\":[true,false,null,-0.5E+3]}\n"});
    add_byte(8'hef, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_doc({"\"\\ud83d\\ude00\\/\"", string'(8'hff)});
    add_doc(nest(64));
    add_doc(nest(65));
    wait_drained();

    // depth extremes and a mid setting
    write_depth(7'd1);
    add_doc("[1]");
    add_doc("[[1]]");
    wait_drained();
    write_depth(7'd0);
    add_doc("[]");
    add_doc("7");
    wait_drained();
    write_depth(7'd127);
    add_doc(nest(64));
    add_doc(nest(65));
    wait_drained();
    write_depth(7'd3);
    run_random(150);
    wait_drained();
    write_depth(7'd64);
    run_random(150);

    // sender holds off until every verdict is back
    while (pending_bytes.size() > 0) @(posedge clk);
    driver_paused = 1'b1;
    while (in_valid || expected_verdicts.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
    driver_paused = 1'b0;
    write_depth(7'd2);
    run_random(140);
    wait_drained();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
